### design/adip_pkg.sv
`default_nettype none

package adip_pkg;

    // Longest accepted number is MAX_CHARS-1 characters, minus included
    localparam int MAX_CHARS = 12;
    localparam int CC_W      = 6;
    localparam int MAG_W     = 33;
    localparam int PROD_W    = MAG_W + 4;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;

    // Target type codes
    localparam logic [2:0] TT_U8  = 3'd0;
    localparam logic [2:0] TT_S8  = 3'd1;
    localparam logic [2:0] TT_S16 = 3'd2;
    localparam logic [2:0] TT_U16 = 3'd3;
    localparam logic [2:0] TT_S32 = 3'd4;

    // Result status; ST_OK doubles as "no error yet" in the parse state
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_BAD_CHAR     = 3'd2,
        ST_TOO_LONG     = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

    // Magnitude limits, positive side and negative side
    localparam logic [MAG_W-1:0] LIM_U8_POS  = 33'd255;
    localparam logic [MAG_W-1:0] LIM_S8_POS  = 33'd127;
    localparam logic [MAG_W-1:0] LIM_S8_NEG  = 33'd128;
    localparam logic [MAG_W-1:0] LIM_S16_POS = 33'd32767;
    localparam logic [MAG_W-1:0] LIM_S16_NEG = 33'd32768;
    localparam logic [MAG_W-1:0] LIM_U16_POS = 33'd65535;
    localparam logic [MAG_W-1:0] LIM_S32_POS = 33'h0_7FFF_FFFF;
    localparam logic [MAG_W-1:0] LIM_S32_NEG = 33'h0_8000_0000;

    function automatic logic type_is_signed(input logic [2:0] tt);
        return (tt == TT_S8) || (tt == TT_S16) || (tt == TT_S32);
    endfunction

endpackage

`default_nettype wire

### design/ascii_decimal_integer_parser_unit.sv
`default_nettype none

// Channel   Dir  Word layout (low bit first)                Handshake
// s_        in   tdata[7:0] rx_byte, tlast burst_end          tvalid/tready
// m_        out  tdata[31:0] value, tuser[0] valid_res,       tvalid/tready
//                tuser[3:1] status
// cfg_      in   cfg_wr_data[2:0] target_type                 cfg_wr_en
//
// One word per cycle sustained unless a tlast word stalls. A word sits in the
// input register, then the parse state and, on tlast, the result register are
// updated. A tlast word passes the input register, then the result register.
// Only tlast words wait on a full result register; other words keep flowing.
// aresetn is synchronous, active low; target_type resets to signed 16-bit.

module ascii_decimal_integer_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,   // [2:0] target_type
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  wire logic        s_tlast,       // burst_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [31:0] value
    output logic [3:0]       m_tuser        // [0] valid_res, [3:1] status
);

    localparam int CC_W   = adip_pkg::CC_W;
    localparam int MAG_W  = adip_pkg::MAG_W;
    localparam int PROD_W = adip_pkg::PROD_W;

    // Configuration
    logic [2:0] target_type_reg;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parse state
    logic [CC_W-1:0]   char_count_reg, char_count_next;
    logic              is_negative_reg, is_negative_next;
    logic [MAG_W-1:0]  magnitude_reg, magnitude_next;
    logic              digit_seen_reg, digit_seen_next;
    adip_pkg::status_t error_kind_reg, error_kind_next;
    logic              dropping_reg, dropping_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_value_reg, out_value_next;
    logic              out_ok_reg, out_ok_next;
    adip_pkg::status_t out_status_reg, out_status_next;

    // Handshake
    logic out_free;
    logic consume;
    logic s_accept;

    // Per-word parse results
    logic [7:0]        ch;
    logic              is_digit;
    logic [3:0]        digit;
    logic [CC_W-1:0]   cc_inc;
    logic [PROD_W-1:0] prod;
    logic [CC_W-1:0]   cc_take;
    logic              neg_take;
    logic [MAG_W-1:0]  mag_take;
    logic              seen_take;
    adip_pkg::status_t err_take;
    logic              drop_take;

    // Result evaluation
    logic              in_range;
    logic [31:0]       signed_value;

    assign out_free = !out_valid_reg || m_tready;
    // Non-final words never produce a result, so they need no room downstream
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_type_reg <= adip_pkg::TT_S16;
        end else if (cfg_wr_en) begin
            target_type_reg <= cfg_wr_data;
        end
    end

    // Take one character into the state
    always_comb begin
        ch       = in_byte_reg;
        is_digit = (ch >= adip_pkg::CH_ZERO) && (ch < adip_pkg::CH_COLON);
        digit    = 4'(ch - adip_pkg::CH_ZERO);
        cc_inc   = char_count_reg + CC_W'(1);
        // x10 as shift-add; saturate once the product leaves 33 bits
        prod     = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                 + {{(PROD_W-4){1'b0}}, digit};

        cc_take   = char_count_reg;
        neg_take  = is_negative_reg;
        mag_take  = magnitude_reg;
        seen_take = digit_seen_reg;
        err_take  = error_kind_reg;
        drop_take = dropping_reg;

        if (!dropping_reg) begin
            priority if (ch == adip_pkg::CH_MINUS && char_count_reg == '0 &&
                         adip_pkg::type_is_signed(target_type_reg)) begin
                neg_take = 1'b1;
                cc_take  = CC_W'(1);
            end else if (is_digit) begin
                cc_take = cc_inc;
                if (cc_inc <= CC_W'(adip_pkg::MAX_CHARS - 1)) begin
                    mag_take  = (prod > PROD_W'(adip_pkg::MAG_MAX)) ?
                                adip_pkg::MAG_MAX : prod[MAG_W-1:0];
                    seen_take = 1'b1;
                end else begin
                    err_take  = adip_pkg::ST_TOO_LONG;
                    drop_take = 1'b1;
                end
            end else if (ch == adip_pkg::CH_LF || ch == adip_pkg::CH_CR) begin
                // line ending only rejects an empty line
                if (char_count_reg == '0) begin
                    err_take  = adip_pkg::ST_EMPTY;
                    drop_take = 1'b1;
                end
            end else begin
                err_take  = adip_pkg::ST_BAD_CHAR;
                drop_take = 1'b1;
            end
        end
    end

    // Range check on sign and magnitude
    always_comb begin
        unique case (target_type_reg)
            adip_pkg::TT_U8:
                in_range = neg_take ? (mag_take == '0) : (mag_take <= adip_pkg::LIM_U8_POS);
            adip_pkg::TT_S8:
                in_range = neg_take ? (mag_take <= adip_pkg::LIM_S8_NEG)
                                    : (mag_take <= adip_pkg::LIM_S8_POS);
            adip_pkg::TT_S16:
                in_range = neg_take ? (mag_take <= adip_pkg::LIM_S16_NEG)
                                    : (mag_take <= adip_pkg::LIM_S16_POS);
            adip_pkg::TT_U16:
                in_range = neg_take ? (mag_take == '0) : (mag_take <= adip_pkg::LIM_U16_POS);
            adip_pkg::TT_S32:
                in_range = neg_take ? (mag_take <= adip_pkg::LIM_S32_NEG)
                                    : (mag_take <= adip_pkg::LIM_S32_POS);
            default:
                in_range = 1'b0;
        endcase
        signed_value = neg_take ? (32'd0 - mag_take[31:0]) : mag_take[31:0];
    end

    // State and result update
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        char_count_next  = char_count_reg;
        is_negative_next = is_negative_reg;
        magnitude_next   = magnitude_reg;
        digit_seen_next  = digit_seen_reg;
        error_kind_next  = error_kind_reg;
        dropping_next    = dropping_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_ok_next     = out_ok_reg;
        out_status_next = out_status_reg;

        if (consume) begin
            if (in_last_reg) begin
                // burst end: report, then start over
                out_valid_next   = 1'b1;
                out_value_next   = '0;
                out_ok_next      = 1'b0;
                if (err_take != adip_pkg::ST_OK) begin
                    out_status_next = err_take;
                end else if (!seen_take) begin
                    out_status_next = adip_pkg::ST_EMPTY;
                end else if (in_range) begin
                    out_value_next  = signed_value;
                    out_ok_next     = 1'b1;
                    out_status_next = adip_pkg::ST_OK;
                end else begin
                    out_status_next = adip_pkg::ST_OUT_OF_RANGE;
                end
                char_count_next  = '0;
                is_negative_next = 1'b0;
                magnitude_next   = '0;
                digit_seen_next  = 1'b0;
                error_kind_next  = adip_pkg::ST_OK;
                dropping_next    = 1'b0;
            end else begin
                char_count_next  = cc_take;
                is_negative_next = neg_take;
                magnitude_next   = mag_take;
                digit_seen_next  = seen_take;
                error_kind_next  = err_take;
                dropping_next    = drop_take;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            char_count_reg  <= '0;
            is_negative_reg <= 1'b0;
            magnitude_reg   <= '0;
            digit_seen_reg  <= 1'b0;
            error_kind_reg  <= adip_pkg::ST_OK;
            dropping_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            char_count_reg  <= char_count_next;
            is_negative_reg <= is_negative_next;
            magnitude_reg   <= magnitude_next;
            digit_seen_reg  <= digit_seen_next;
            error_kind_reg  <= error_kind_next;
            dropping_reg    <= dropping_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_value_reg  <= out_value_next;
        out_ok_reg     <= out_ok_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_status_reg, out_ok_reg};

endmodule

`default_nettype wire

### design/adip_checker.sv
`default_nettype none

module adip_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    // No result may be pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A good number always carries status OK
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == adip_pkg::ST_OK))
        else $error("valid_res with non-OK status");

    // A rejected number reads as zero and carries an error status
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0 &&
         (m_tuser[3:1] == adip_pkg::ST_EMPTY || m_tuser[3:1] == adip_pkg::ST_BAD_CHAR ||
          m_tuser[3:1] == adip_pkg::ST_TOO_LONG ||
          m_tuser[3:1] == adip_pkg::ST_OUT_OF_RANGE)))
        else $error("rejected result not zero or bad status");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind ascii_decimal_integer_parser_unit adip_checker u_adip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
